// ===== design/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache tag block.
// Used by salc_ctrl, salc_datapath and the top level.
package salc_pkg;

  localparam int MAX_SETS_DEF = 32;
  localparam int MAX_WAYS_DEF = 8;

  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int AGE_W      = 3;
  localparam int WCNT_W     = 5;   // holds a way count up to sixteen
  localparam int RAW_SET_W  = 7;   // set index before wrap, index width up to 7

  localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE  = 2'd2;

  localparam logic [2:0] OFFSET_WIDTH_RST = 3'd5;
  localparam logic [2:0] INDEX_WIDTH_RST  = 3'd2;
  localparam logic [3:0] WAYS_IN_USE_RST  = 4'd1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_t;

  typedef struct packed {
    logic accept;   // latch address, read the set row
    logic update;   // write back the row, register the result
    logic clear;    // write an empty row at the sweep counter
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctrl_status_t;

endpackage

// ===== design/set_assoc_lru_cache_tag_sim.sv =====
// Set-associative cache tag lookup with age-counter LRU replacement.
// Result: the done strobe is registered from the lookup state, which follows the
// accept of a start transfer. No new address is taken until the set RAM read and
// the read-modify-write of the same row are done. Results cannot be stalled.
// Reset: config returns to defaults, then a clearing sweep writes an empty row to
// every set with busy high; config writes are taken during it.
module set_assoc_lru_cache_tag_sim
  import salc_pkg::*;
#(
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_W-1:0]     address,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic                  hit,
  output logic [2:0]            way_used,
  output logic                  evicted,
  output logic [31:0]           hit_total,
  output logic [31:0]           miss_total
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  salc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  salc_datapath #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .address    (address),
    .done       (done),
    .hit        (hit),
    .way_used   (way_used),
    .evicted    (evicted),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

  // an accepted address holds the block busy for its lookup cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && cmd.update && !done))
    else $error("lookup cycle missing after start transfer");

  // a result only follows a lookup cycle
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.update))
    else $error("result strobe without lookup");

  // no work is taken while the sweep runs
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> (busy && !cmd.accept && !cmd.update))
    else $error("transfer during clearing sweep");

  // a miss result always carries a nonzero miss total
  a_miss_count: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (miss_total != 32'd0 && !(evicted && hit)))
    else $error("miss result with zero miss total");

endmodule

// ===== design/salc_ctrl.sv =====
// Controller for the cache tag block: clearing sweep, idle, lookup.
// Depends on salc_pkg; drives salc_datapath through ctrl_cmd_t.
module salc_ctrl
  import salc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  ctrl_status_t status,
  output logic         busy,
  output ctrl_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/salc_datapath.sv =====
// Datapath: configuration registers, set RAM (valid, age, tag rows),
// hit/victim search, age update, saturating totals. Depends on salc_pkg.
module salc_datapath
  import salc_pkg::*;
#(
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output ctrl_status_t          status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ADDR_W-1:0]     address,
  output logic                  done,
  output logic                  hit,
  output logic [2:0]            way_used,
  output logic                  evicted,
  output logic [31:0]           hit_total,
  output logic [31:0]           miss_total
);

  localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RAW_SETS = 1 << RAW_SET_W;

  // configuration
  logic [2:0] offset_width;
  logic [2:0] index_width;
  logic [3:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_width <= OFFSET_WIDTH_RST;
      index_width  <= INDEX_WIDTH_RST;
      ways_in_use  <= WAYS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_WIDTH: offset_width <= cfg_data[2:0];
        CFG_INDEX_WIDTH:  index_width  <= cfg_data[2:0];
        CFG_WAYS_IN_USE:  ways_in_use  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the way count to 1..MAX_WAYS
  logic [WCNT_W-1:0] nways;
  always_comb begin
    if (ways_in_use == 4'd0) begin
      nways = WCNT_W'(1);
    end else if ({1'b0, ways_in_use} > WCNT_W'(MAX_WAYS)) begin
      nways = WCNT_W'(MAX_WAYS);
    end else begin
      nways = {1'b0, ways_in_use};
    end
  end

  // set index wrap table, built at elaboration
  logic [SET_W-1:0] set_lut [RAW_SETS];
  for (genvar i = 0; i < RAW_SETS; i++) begin : g_set_lut
    assign set_lut[i] = SET_W'(i % MAX_SETS);
  end

  logic [ADDR_W-1:0]    addr_shift;
  logic [RAW_SET_W-1:0] set_mask;
  logic [RAW_SET_W-1:0] set_raw;
  logic [SET_W-1:0]     set_in;
  logic [ADDR_W-1:0]    tag_in;

  assign addr_shift = address >> offset_width;
  assign set_mask   = (RAW_SET_W'(1) << index_width) - RAW_SET_W'(1);
  assign set_raw    = addr_shift[RAW_SET_W-1:0] & set_mask;
  assign set_in     = set_lut[set_raw];
  assign tag_in     = address >> ({1'b0, offset_width} + {1'b0, index_width});

  logic [SET_W-1:0]  cur_set;
  logic [ADDR_W-1:0] cur_tag;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_set <= set_in;
      cur_tag <= tag_in;
    end
  end

  // clearing sweep counter
  logic [SET_W-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + SET_W'(1);
    end
  end
  assign status.clear_last = (clr_cnt == SET_W'(MAX_SETS - 1));

  // set RAM: one row per set, one write and one registered read port
  logic [MAX_WAYS-1:0]                valid_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][AGE_W-1:0]     age_mem   [MAX_SETS];
  logic [MAX_WAYS-1:0][ADDR_W-1:0]    tag_mem   [MAX_SETS];

  logic [MAX_WAYS-1:0]                rd_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]     rd_age;
  logic [MAX_WAYS-1:0][ADDR_W-1:0]    rd_tag;

  logic [MAX_WAYS-1:0]                new_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]     new_age;
  logic [MAX_WAYS-1:0][ADDR_W-1:0]    new_tag;

  logic             wr_en;
  logic [SET_W-1:0] wr_set;

  assign wr_en  = cmd.update | cmd.clear;
  assign wr_set = cmd.clear ? clr_cnt : cur_set;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      valid_mem[wr_set] <= cmd.clear ? '0 : new_valid;
      age_mem[wr_set]   <= cmd.clear ? '0 : new_age;
      tag_mem[wr_set]   <= cmd.clear ? '0 : new_tag;
    end
    if (cmd.accept) begin
      rd_valid <= valid_mem[set_in];
      rd_age   <= age_mem[set_in];
      rd_tag   <= tag_mem[set_in];
    end
  end

  // hit, first free way and oldest way in the row
  logic [MAX_WAYS-1:0] in_use;
  logic                found_hit;
  logic                found_inv;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    vic_way;
  logic [AGE_W-1:0]    best_age;

  always_comb begin
    found_hit = 1'b0;
    found_inv = 1'b0;
    hit_way   = '0;
    inv_way   = '0;
    vic_way   = '0;
    best_age  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (WCNT_W'(w) < nways);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && rd_valid[w] && (rd_tag[w] == cur_tag) && !found_hit) begin
        found_hit = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (in_use[w] && !rd_valid[w] && !found_inv) begin
        found_inv = 1'b1;
        inv_way   = WAY_W'(w);
      end
    end
    // first way with the largest age; way 0 when all are equal
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && (rd_age[w] > best_age)) begin
        best_age = rd_age[w];
        vic_way  = WAY_W'(w);
      end
    end
  end

  logic [WAY_W-1:0] sel_way;
  logic [AGE_W-1:0] old_age;
  logic             evict_now;

  assign sel_way   = found_hit ? hit_way : (found_inv ? inv_way : vic_way);
  assign old_age   = rd_age[hit_way];
  assign evict_now = !found_hit && !found_inv;

  always_comb begin
    new_valid = rd_valid;
    new_age   = rd_age;
    new_tag   = rd_tag;
    for (int w = 0; w < MAX_WAYS; w++) begin
      // a hit ages only the lines younger than it; a miss ages every valid line; none pass AGE_MAX
      if (in_use[w] && rd_valid[w] && (!found_hit || (rd_age[w] < old_age))
          && (rd_age[w] != AGE_MAX)) begin
        new_age[w] = rd_age[w] + AGE_W'(1);
      end
    end
    new_valid[sel_way] = 1'b1;
    new_age[sel_way]   = '0;
    new_tag[sel_way]   = cur_tag;
  end

  // result registers and saturating totals
  logic [WAY_W+2:0] way_wide;
  assign way_wide = (WAY_W + 3)'(sel_way);

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
    end else begin
      done <= cmd.update;
      if (cmd.update) begin
        if (found_hit) begin
          if (hit_total != '1) begin
            hit_total <= hit_total + 32'd1;
          end
        end else if (miss_total != '1) begin
          miss_total <= miss_total + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit      <= found_hit;
      way_used <= way_wide[2:0];
      evicted  <= evict_now;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for set_assoc_lru_cache_tag_sim: tag hit/miss, LRU way choice,
// eviction and running totals are predicted in a scoreboard class and compared per result.
// Depends on salc_pkg and the RTL top level only.
`timescale 1ns / 100ps

typedef struct packed {
  logic        hit;
  logic [2:0]  way;
  logic        evicted;
  logic [31:0] hits_total;
  logic [31:0] misses_total;
} lookup_result_t;

class tag_lookup_predictor;
  bit             line_ok[salc_pkg::MAX_SETS_DEF * salc_pkg::MAX_WAYS_DEF];
  logic [31:0]    line_tag[salc_pkg::MAX_SETS_DEF * salc_pkg::MAX_WAYS_DEF];
  bit   [2:0]     line_age[salc_pkg::MAX_SETS_DEF * salc_pkg::MAX_WAYS_DEF];
  bit   [31:0]    hits_so_far;
  bit   [31:0]    misses_so_far;
  int             off_w;
  int             idx_w;
  int             ways;
  lookup_result_t pending_lookups[$];
  int             errors;

  function new();
    off_w = salc_pkg::OFFSET_WIDTH_RST;
    idx_w = salc_pkg::INDEX_WIDTH_RST;
    ways  = salc_pkg::WAYS_IN_USE_RST;
  endfunction

  function void set_register(logic [salc_pkg::CFG_IDX_W-1:0] idx,
                             logic [salc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      salc_pkg::CFG_OFFSET_WIDTH: off_w = data[2:0];
      salc_pkg::CFG_INDEX_WIDTH:  idx_w = data[2:0];
      salc_pkg::CFG_WAYS_IN_USE:  ways  = data;
      default: ;
    endcase
  endfunction

  function bit [31:0] sat_inc(bit [31:0] count);
    return (count == '1) ? count : count + 32'd1;
  endfunction

  function void note_access(logic [31:0] addr);
    lookup_result_t r;
    int             n;
    int             base;
    int             w;
    logic [31:0]    raw_set;
    logic [31:0]    tag;
    bit   [2:0]     old_age;
    bit   [2:0]     oldest;
    bit             empty_found;
    r = '0;
    empty_found = 1'b0;
    n = (ways < 1) ? 1 : (ways > salc_pkg::MAX_WAYS_DEF) ? salc_pkg::MAX_WAYS_DEF : ways;
    raw_set = (addr >> off_w) & ((32'd1 << idx_w) - 32'd1);
    base = int'(raw_set % salc_pkg::MAX_SETS_DEF) * salc_pkg::MAX_WAYS_DEF;
    tag = addr >> (off_w + idx_w);
    for (w = 0; w < n; w++)
      if (!r.hit && line_ok[base + w] && line_tag[base + w] == tag) begin
        r.hit = 1'b1;
        r.way = 3'(w);
      end
    if (r.hit) begin
      hits_so_far = sat_inc(hits_so_far);
      old_age = line_age[base + r.way];
      for (w = 0; w < n; w++)
        if (line_ok[base + w] && line_age[base + w] < old_age)
          line_age[base + w]++;
      line_age[base + r.way] = '0;
    end else begin
      misses_so_far = sat_inc(misses_so_far);
      for (w = 0; w < n; w++)
        if (!empty_found && !line_ok[base + w]) begin
          empty_found = 1'b1;
          r.way = 3'(w);
        end
      if (!empty_found) begin
        // first way with the largest age, way 0 on a tie
        oldest = '0;
        r.way = '0;
        r.evicted = 1'b1;
        for (w = 0; w < n; w++)
          if (line_age[base + w] > oldest) begin
            oldest = line_age[base + w];
            r.way = 3'(w);
          end
      end
      for (w = 0; w < n; w++)
        if (line_ok[base + w] && line_age[base + w] != salc_pkg::AGE_MAX)
          line_age[base + w]++;
      line_ok[base + r.way]  = 1'b1;
      line_tag[base + r.way] = tag;
      line_age[base + r.way] = '0;
    end
    r.hits_total = hits_so_far;
    r.misses_total = misses_so_far;
    pending_lookups = {pending_lookups, r};
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  function void check_result(lookup_result_t got);
    lookup_result_t want;
    if (pending_lookups.size() == 0) begin
      errors++;
      $display("%0t: result with no lookup pending, actual hit %0b way %0d",
               $time, got.hit, got.way);
      return;
    end
    want = pending_lookups.pop_front();
    compare("hit", want.hit, got.hit);
    compare("way_used", want.way, got.way);
    compare("evicted", want.evicted, got.evicted);
    compare("hit_total", want.hits_total, got.hits_total);
    compare("miss_total", want.misses_total, got.misses_total);
  endfunction

  function int pending();
    return pending_lookups.size();
  endfunction
endclass

module tb;
  import salc_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 115;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic [ADDR_W-1:0]     address   = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  busy;
  logic                  done;
  logic                  hit;
  logic [2:0]            way_used;
  logic                  evicted;
  logic [31:0]           hit_total;
  logic [31:0]           miss_total;

  int                  stall_cycles = 0;
  int                  cur_off = OFFSET_WIDTH_RST;
  int                  cur_idx = INDEX_WIDTH_RST;
  logic [31:0]         tag_pool[16];
  tag_lookup_predictor lookups;

  set_assoc_lru_cache_tag_sim dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .address   (address),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .hit       (hit),
    .way_used  (way_used),
    .evicted   (evicted),
    .hit_total (hit_total),
    .miss_total(miss_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done)
      lookups.check_result({hit, way_used, evicted, hit_total, miss_total});
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    lookups.set_register(idx, data);
  endtask

  // upper data bit of the 3-bit registers is random: it must be dropped
  task automatic write_config(input logic [2:0] off_w, input logic [2:0] idx_w,
                              input logic [3:0] ways);
    put_register(CFG_OFFSET_WIDTH, {1'($urandom_range(0, 1)), off_w});
    put_register(CFG_INDEX_WIDTH, {1'($urandom_range(0, 1)), idx_w});
    put_register(CFG_WAYS_IN_USE, ways);
    put_register(CFG_SPARE, 4'($urandom));
    cfg_we  <= 1'b0;
    cur_off = off_w;
    cur_idx = idx_w;
  endtask

  task automatic send_access(input logic [31:0] addr, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    lookups.note_access(addr);
  endtask

  // hold off new transfers until every result is back
  task automatic drain();
    start <= 1'b0;
    while (lookups.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // tags from a small pool on a few sets, so lines hit, fill and get evicted
  function automatic logic [31:0] pick_address(input int pool_n);
    logic [31:0] off_mask;
    logic [31:0] idx_mask;
    logic [31:0] set_sel;
    off_mask = (32'd1 << cur_off) - 32'd1;
    idx_mask = (32'd1 << cur_idx) - 32'd1;
    set_sel  = $urandom_range(0, 3);
    // high set bits alias onto low sets after the wrap
    if (cur_idx > 5 && $urandom_range(0, 1) == 1)
      set_sel += 32'd32 * $urandom_range(1, 3);
    if ($urandom_range(0, 99) < 12)
      return $urandom;
    return (tag_pool[$urandom_range(0, pool_n - 1)] << (cur_off + cur_idx))
         | ((set_sel & idx_mask) << cur_off) | ($urandom & off_mask);
  endfunction

  initial begin
    logic [2:0] off_w;
    logic [2:0] idx_w;
    logic [3:0] ways;
    int         idle_pct;
    int         pool_n;
    int         k;
    lookups = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // settings after reset: direct mapped, same block twice
    send_access(32'h0000_0040, 0);
    send_access(32'h0000_0044, 0);
    drain();

    // two ways, whole address is the tag: fill, hit, evict the older line
    write_config(3'd0, 3'd0, 4'd2);
    send_access(32'h0000_0000, 0);
    send_access(32'h0000_0000, 0);
    send_access(32'hFFFF_FFFF, 0);
    send_access(32'h0000_0000, 0);
    send_access(32'h0000_0001, 0);
    send_access(32'h0000_0000, 0);
    drain();

    // widths above range, zero ways: set 35 wraps onto set 3 and aliases
    write_config(3'd7, 3'd7, 4'd0);
    send_access(32'h0000_0000, 0);
    send_access(32'hFFFF_FFFF, 0);
    send_access(32'd3 << 7, 0);
    send_access(32'd35 << 7, 0);
    send_access(32'h0000_4000, 0);
    send_access(32'h0000_0000, 0);
    drain();

    // ways above range act as all eight: fill one set, evict, hit
    write_config(3'd6, 3'd5, 4'd15);
    for (k = 0; k <= 8; k++)
      send_access(32'(k) << 11, 0);
    send_access(32'd2 << 11, 0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin off_w = 3'd0; idx_w = 3'd0; ways = 4'd1;  end
        1: begin off_w = 3'd6; idx_w = 3'd5; ways = 4'd8;  end
        2: begin off_w = 3'd7; idx_w = 3'd7; ways = 4'd15; end
        3: begin off_w = 3'd2; idx_w = 3'd6; ways = 4'd0;  end
        default: begin
          off_w = 3'($urandom_range(0, 7));
          idx_w = 3'($urandom_range(0, 7));
          ways  = 4'($urandom_range(0, 15));
        end
      endcase
      write_config(off_w, idx_w, ways);
      foreach (tag_pool[j]) tag_pool[j] = $urandom;
      pool_n = int'(ways) + $urandom_range(1, 4);
      if (pool_n > 16) pool_n = 16;
      // no idling in the closing phases and in every third one
      idle_pct = (p >= RANDOM_PHASES - 2 || p % 3 == 1) ? 0 : $urandom_range(10, 50);
      for (k = 0; k < PHASE_ITEMS; k++)
        send_access(pick_address(pool_n),
                    ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 19) : 0);
      drain();
    end

    repeat (4) @(posedge clk);
    if (lookups.errors == 0 && lookups.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
